// File: hw/rtl/ffsc_pkg.sv
package ffsc_pkg;

    // Frame geometry and field widths.
    localparam int FRAME_LENGTH = 10;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 4;
    localparam int FILL_W       = 4;
    localparam int CFG_IDX_W    = 2;

    // Checksum covers bytes SUM_FIRST..SUM_LAST and sits at SUM_POS.
    localparam int SUM_FIRST = 1;
    localparam int SUM_LAST  = 7;
    localparam int SUM_POS   = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_MARKER   = 2'd2;

    // Register reset values.
    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_MARKER_RST   = 8'h6B;

    // Window fill at which the next byte completes a candidate frame.
    localparam logic [FILL_W-1:0] FILL_LAST = 4'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0]  POS_LAST  = 4'(FRAME_LENGTH - 1);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [FRAME_LENGTH-1:0][BYTE_W-1:0] frame_t;

    // Status of the frame queue, seen by the back and by the input stall logic.
    typedef struct packed {
        logic full;
        logic empty;
    } fq_status_t;

endpackage

// File: hw/rtl/ffsc_front.sv
module ffsc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ffsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffsc_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           accept,
    input  ffsc_pkg::byte_t                rx_byte,
    output logic                           frame_push,
    output ffsc_pkg::frame_t               frame_data
);

    ffsc_pkg::byte_t first_header_reg;
    ffsc_pkg::byte_t second_header_reg;
    ffsc_pkg::byte_t tail_marker_reg;

    logic [ffsc_pkg::FILL_W-1:0] fill_reg;
    logic [ffsc_pkg::FILL_W-1:0] fill_next;
    ffsc_pkg::byte_t win_reg  [ffsc_pkg::FRAME_LENGTH-1];
    ffsc_pkg::byte_t win_next [ffsc_pkg::FRAME_LENGTH-1];

    ffsc_pkg::frame_t cand;
    ffsc_pkg::byte_t  sum;
    logic             win_full;
    logic             frame_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_header_reg  <= ffsc_pkg::FIRST_HEADER_RST;
            second_header_reg <= ffsc_pkg::SECOND_HEADER_RST;
            tail_marker_reg   <= ffsc_pkg::TAIL_MARKER_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ffsc_pkg::REG_FIRST_HEADER:  first_header_reg  <= cfg_data;
                ffsc_pkg::REG_SECOND_HEADER: second_header_reg <= cfg_data;
                ffsc_pkg::REG_TAIL_MARKER:   tail_marker_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // The incoming byte completes the frame when nine bytes are held.
    always_comb
    begin
        for (int k = 0; k < ffsc_pkg::FRAME_LENGTH - 1; k++)
        begin
            cand[k] = win_reg[k];
        end
        cand[ffsc_pkg::FRAME_LENGTH-1] = rx_byte;

        sum = '0;
        for (int k = ffsc_pkg::SUM_FIRST; k <= ffsc_pkg::SUM_LAST; k++)
        begin
            sum = sum + cand[k];
        end

        win_full = (fill_reg == ffsc_pkg::FILL_LAST);
        frame_ok = (cand[0] == first_header_reg)
                && (cand[1] == second_header_reg)
                && (cand[ffsc_pkg::FRAME_LENGTH-1] == tail_marker_reg)
                && (cand[ffsc_pkg::SUM_POS] == sum);
    end

    assign frame_push = accept && win_full && frame_ok;
    assign frame_data = cand;

    always_comb
    begin
        fill_next = fill_reg;
        win_next  = win_reg;
        if (accept)
        begin
            if (win_full)
            begin
                if (frame_ok)
                begin
                    fill_next = '0;
                end
                else
                begin
                    // Drop the oldest byte and keep the remaining nine.
                    for (int k = 0; k < ffsc_pkg::FRAME_LENGTH - 1; k++)
                    begin
                        win_next[k] = cand[k+1];
                    end
                end
            end
            else
            begin
                win_next[fill_reg] = rx_byte;
                fill_next          = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// File: hw/rtl/ffsc_fq.sv
module ffsc_fq #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ffsc_pkg::frame_t       push_data,
    input  logic                   pop,
    output ffsc_pkg::frame_t       head,
    output ffsc_pkg::fq_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ffsc_pkg::frame_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/ffsc_back.sv
module ffsc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffsc_pkg::frame_t            head,
    input  ffsc_pkg::fq_status_t        fq_status,
    input  logic                        pop,
    output logic                        empty,
    output logic                        frame_pop,
    output logic [ffsc_pkg::BYTE_W-1:0] frame_byte,
    output logic [ffsc_pkg::POS_W-1:0]  byte_position,
    output logic                        last_of_frame
);

    logic [ffsc_pkg::POS_W-1:0] pos_reg;
    logic [ffsc_pkg::POS_W-1:0] pos_next;
    logic                       take;

    assign empty         = fq_status.empty;
    assign take          = pop && !fq_status.empty;
    assign frame_byte    = head[pos_reg];
    assign byte_position = pos_reg;
    assign last_of_frame = (pos_reg == ffsc_pkg::POS_LAST);
    // The frame leaves the queue together with its final byte.
    assign frame_pop     = take && last_of_frame;

    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            pos_next = last_of_frame ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: hw/rtl/fixed_frame_sync_checksum_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        rx_byte
// result    out        pop / empty        frame_byte, byte_position, last_of_frame
// config    in         cfg_wen            cfg_index, cfg_data
//
// One received byte is taken every cycle while full is low; the frame check is
// done in the same cycle the byte arrives, so a good frame is visible on the
// result side in the cycle after its tail byte. A frame then leaves as ten
// results, one per cycle while pop is high. Reset clears the window fill, the
// queue and the result position, and loads the default header and tail values.
// full rises only when the frame queue holds QUEUE_DEPTH frames not yet drained.
module fixed_frame_sync_checksum_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ffsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffsc_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ffsc_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [ffsc_pkg::BYTE_W-1:0]    frame_byte,
    output logic [ffsc_pkg::POS_W-1:0]     byte_position,
    output logic                           last_of_frame
);

    // The front stage holds the sliding window of the last nine bytes and
    // checks each candidate frame as its final byte arrives. A frame that
    // passes is written whole into the frame queue.
    ffsc_pkg::frame_t     push_frame;
    ffsc_pkg::frame_t     head_frame;
    ffsc_pkg::fq_status_t fq_status;
    logic                 in_accept;
    logic                 frame_push;
    logic                 frame_pop;

    // Input requests stall only on a full frame queue; the window itself
    // never blocks.
    assign full      = fq_status.full;
    assign in_accept = push && !full;

    ffsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (in_accept),
        .rx_byte    (rx_byte),
        .frame_push (frame_push),
        .frame_data (push_frame)
    );

    // The frame queue decouples the two sides: the front keeps taking bytes
    // while the back is still draining an earlier frame.
    ffsc_fq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_push),
        .push_data (push_frame),
        .pop       (frame_pop),
        .head      (head_frame),
        .status    (fq_status)
    );

    // The back stage walks the head frame byte by byte and releases it from
    // the queue when the last byte is taken.
    ffsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_frame),
        .fq_status     (fq_status),
        .pop           (pop),
        .empty         (empty),
        .frame_pop     (frame_pop),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_of_frame (last_of_frame)
    );

    // A frame is never offered to a queue that cannot take it.
    a_no_push_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        frame_push |-> !fq_status.full
    ) else $error("frame offered to a full frame queue");

    // A partly drained frame must still be in the queue.
    a_pos_needs_frame : assert property (
        @(posedge clk) disable iff (!rst_n)
        (byte_position != '0) |-> !empty
    ) else $error("byte position advanced with no frame queued");

    // After the final byte of a frame is taken, the next frame starts at zero.
    a_pos_wraps : assert property (
        @(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_of_frame) |=> (byte_position == '0)
    ) else $error("byte position did not restart after a frame");

endmodule

// File: bench/ffsc_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, byte and frame channels, keeps its own copy of
// the sync window and checks every frame byte that leaves the block.
module ffsc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ffsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffsc_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic [ffsc_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [ffsc_pkg::BYTE_W-1:0]    frame_byte,
    input  logic [ffsc_pkg::POS_W-1:0]     byte_position,
    input  logic                           last_of_frame,
    output int                             mismatch_count,
    output int                             expected_left
);

    typedef struct packed {
        ffsc_pkg::byte_t            data;
        logic [ffsc_pkg::POS_W-1:0] pos;
        logic                       last;
    } frame_beat_t;

    ffsc_pkg::byte_t want_first;
    ffsc_pkg::byte_t want_second;
    ffsc_pkg::byte_t want_tail;
    ffsc_pkg::byte_t sync_window [ffsc_pkg::FRAME_LENGTH];
    int              window_fill;
    int              errs = 0;
    frame_beat_t     pending_beats [$];

    // A full window is a frame when the headers, the tail and the checksum match.
    function automatic logic window_holds_frame();
        ffsc_pkg::byte_t sum;
        sum = '0;
        for (int k = ffsc_pkg::SUM_FIRST; k <= ffsc_pkg::SUM_LAST; k++)
            sum = sum + sync_window[k];
        return sync_window[0] == want_first && sync_window[1] == want_second &&
               sync_window[ffsc_pkg::FRAME_LENGTH-1] == want_tail &&
               sync_window[ffsc_pkg::SUM_POS] == sum;
    endfunction

    task automatic absorb_rx_byte(input ffsc_pkg::byte_t b);
        frame_beat_t beat;
        sync_window[window_fill] = b;
        window_fill++;
        if (window_fill == ffsc_pkg::FRAME_LENGTH)
        begin
            if (window_holds_frame())
            begin
                for (int k = 0; k < ffsc_pkg::FRAME_LENGTH; k++)
                begin
                    beat.data = sync_window[k];
                    beat.pos  = ffsc_pkg::POS_W'(k);
                    beat.last = (k == ffsc_pkg::FRAME_LENGTH - 1);
                    pending_beats.push_back(beat);
                end
                window_fill = 0;
            end
            else
            begin
                for (int k = 0; k < ffsc_pkg::FRAME_LENGTH - 1; k++)
                    sync_window[k] = sync_window[k+1];
                window_fill = ffsc_pkg::FRAME_LENGTH - 1;
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        frame_beat_t want;
        if (!rst_n)
        begin
            want_first  = ffsc_pkg::FIRST_HEADER_RST;
            want_second = ffsc_pkg::SECOND_HEADER_RST;
            want_tail   = ffsc_pkg::TAIL_MARKER_RST;
            window_fill = 0;
            pending_beats.delete();
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    ffsc_pkg::REG_FIRST_HEADER:  want_first  = cfg_data;
                    ffsc_pkg::REG_SECOND_HEADER: want_second = cfg_data;
                    ffsc_pkg::REG_TAIL_MARKER:   want_tail   = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                absorb_rx_byte(rx_byte);
            if (pop && !empty)
            begin
                if (pending_beats.size() == 0)
                begin
                    $display("%0t: unexpected frame byte: expected none, got %h pos %0d last %b",
                             $time, frame_byte, byte_position, last_of_frame);
                    errs++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        $display("%0t: frame_byte expected %h, got %h",
                                 $time, want.data, frame_byte);
                        errs++;
                    end
                    if (byte_position !== want.pos)
                    begin
                        $display("%0t: byte_position expected %0d, got %0d",
                                 $time, want.pos, byte_position);
                        errs++;
                    end
                    if (last_of_frame !== want.last)
                    begin
                        $display("%0t: last_of_frame expected %b, got %b",
                                 $time, want.last, last_of_frame);
                        errs++;
                    end
                end
            end
        end
        mismatch_count <= errs;
        expected_left  <= pending_beats.size();
    end

endmodule

// File: bench/fixed_frame_sync_checksum_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the frame synchronizer. The checker beside the
// block does all prediction and comparison; this module only makes traffic
// on the three channels and decides pass or fail at the end.
module fixed_frame_sync_checksum_unit_tb;

    // The register map leaves index 3 unused; writes to it must do nothing.
    localparam logic [ffsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Longest run of cycles with no request accepted on either side before
    // the run is declared hung. A correct run never gets near this.
    localparam int STALL_LIMIT = 5000;

    // Cycles to wait after the last frame byte, covering the queue write
    // between a tail byte and its frame showing up.
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        FLAW_NONE,
        FLAW_FIRST_HEADER,
        FLAW_SECOND_HEADER,
        FLAW_TAIL,
        FLAW_CHECKSUM
    } frame_flaw_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wen = 1'b0;
    logic [ffsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ffsc_pkg::BYTE_W-1:0]    cfg_data = '0;
    logic                           push = 1'b0;
    logic                           full;
    logic [ffsc_pkg::BYTE_W-1:0]    rx_byte = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [ffsc_pkg::BYTE_W-1:0]    frame_byte;
    logic [ffsc_pkg::POS_W-1:0]     byte_position;
    logic                           last_of_frame;

    int mismatch_count;
    int expected_left;

    // When set, neither side inserts any idle cycles.
    logic steady = 1'b0;

    // Stimulus-side copy of the framing registers, used only to build frames.
    ffsc_pkg::byte_t cur_first  = ffsc_pkg::FIRST_HEADER_RST;
    ffsc_pkg::byte_t cur_second = ffsc_pkg::SECOND_HEADER_RST;
    ffsc_pkg::byte_t cur_tail   = ffsc_pkg::TAIL_MARKER_RST;
    int              bytes_sent = 0;
    int              stall_cycles = 0;

    fixed_frame_sync_checksum_unit dut (.*);
    ffsc_checker                   u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls in roughly a quarter of all cycles unless the
    // steady stretch is running.
    always @(posedge clk)
        pop <= steady || ($urandom_range(99) >= 26);

    // Watchdog: any accepted request on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("fixed_frame_sync_checksum_unit_tb: errors");
            $finish;
        end
    end

    // Offers one byte and returns at the edge where it is accepted. A
    // one-cycle gap is inserted before about a third of the bytes, which
    // leaves the sender idle in about a quarter of its cycles.
    task automatic send_byte(input ffsc_pkg::byte_t b);
        if (!steady && $urandom_range(99) < 35)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // Sends one frame built for the current registers. A flaw breaks one of the
    // four checks (two for the second header), so the window slides past it.
    task automatic send_frame(input frame_flaw_t flaw);
        ffsc_pkg::byte_t frame [ffsc_pkg::FRAME_LENGTH];
        ffsc_pkg::byte_t sum;
        frame[0] = cur_first;
        frame[1] = cur_second;
        sum = cur_second;
        for (int k = 2; k <= ffsc_pkg::SUM_LAST; k++)
        begin
            frame[k] = ffsc_pkg::byte_t'($urandom_range(255));
            sum = sum + frame[k];
        end
        frame[ffsc_pkg::SUM_POS] = sum;
        frame[ffsc_pkg::FRAME_LENGTH-1] = cur_tail;
        case (flaw)
            FLAW_FIRST_HEADER:
                frame[0] ^= ffsc_pkg::byte_t'($urandom_range(1, 255));
            FLAW_SECOND_HEADER:
                frame[1] ^= ffsc_pkg::byte_t'($urandom_range(1, 255));
            FLAW_TAIL:
                frame[ffsc_pkg::FRAME_LENGTH-1] ^= ffsc_pkg::byte_t'($urandom_range(1, 255));
            FLAW_CHECKSUM:
                frame[ffsc_pkg::SUM_POS] ^= ffsc_pkg::byte_t'($urandom_range(1, 255));
            default: ;
        endcase
        for (int k = 0; k < ffsc_pkg::FRAME_LENGTH; k++)
            send_byte(frame[k]);
    endtask

    // Holds the sender off until every predicted frame byte has been taken.
    // The first edge lets the checker see the last accepted byte.
    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ffsc_pkg::CFG_IDX_W-1:0] idx,
                             input ffsc_pkg::byte_t value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Reprograms the framing only while the block is idle. A partly filled
    // window survives the change, which the checker models as well.
    task automatic set_framing(input ffsc_pkg::byte_t first, input ffsc_pkg::byte_t second,
                               input ffsc_pkg::byte_t tail);
        wait_until_drained();
        repeat (4) @(posedge clk);
        write_reg(ffsc_pkg::REG_FIRST_HEADER, first);
        write_reg(ffsc_pkg::REG_SECOND_HEADER, second);
        write_reg(ffsc_pkg::REG_TAIL_MARKER, tail);
        write_reg(REG_UNUSED, ffsc_pkg::byte_t'($urandom_range(255)));
        cfg_wen <= 1'b0;
        cur_first  = first;
        cur_second = second;
        cur_tail   = tail;
    endtask

    // Mostly well-formed frames with random payloads, some broken frames
    // and short bursts of line noise in between.
    task automatic random_traffic(input int budget);
        int stop_at;
        int pick;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(FLAW_NONE);
            else if (pick < 82)
                send_frame(frame_flaw_t'($urandom_range(FLAW_FIRST_HEADER, FLAW_CHECKSUM)));
            else
                repeat ($urandom_range(1, 4)) send_byte(ffsc_pkg::byte_t'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset framing. Leading junk must be slid
        // out before the good frame lines up in the window.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        // A good frame whose payload is all ones, so the checksum wraps.
        send_byte(ffsc_pkg::FIRST_HEADER_RST);
        send_byte(ffsc_pkg::SECOND_HEADER_RST);
        repeat (6) send_byte(8'hFF);
        send_byte(ffsc_pkg::SECOND_HEADER_RST + 8'(6 * 8'hFF));
        send_byte(ffsc_pkg::TAIL_MARKER_RST);
        // A frame that is right in every way except its checksum.
        send_byte(ffsc_pkg::FIRST_HEADER_RST);
        send_byte(ffsc_pkg::SECOND_HEADER_RST);
        repeat (6) send_byte(8'h00);
        send_byte(ffsc_pkg::SECOND_HEADER_RST + 8'h01);
        send_byte(ffsc_pkg::TAIL_MARKER_RST);

        // The broken frame is still in the window when the registers change.
        set_framing(8'h00, 8'h00, 8'h00);
        random_traffic(60);
        set_framing(8'hFF, 8'hFF, 8'hFF);
        random_traffic(60);

        // A stretch with no idling on either side.
        set_framing(ffsc_pkg::byte_t'($urandom_range(255)),
                    ffsc_pkg::byte_t'($urandom_range(255)),
                    ffsc_pkg::byte_t'($urandom_range(255)));
        steady = 1'b1;
        random_traffic(80);
        steady = 1'b0;

        repeat (3)
        begin
            set_framing(ffsc_pkg::byte_t'($urandom_range(255)),
                        ffsc_pkg::byte_t'($urandom_range(255)),
                        ffsc_pkg::byte_t'($urandom_range(255)));
            random_traffic(60);
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_left == 0)
            $display("fixed_frame_sync_checksum_unit_tb: clean");
        else
            $display("fixed_frame_sync_checksum_unit_tb: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ffsc_pkg.sv
hw/rtl/ffsc_front.sv
hw/rtl/ffsc_fq.sv
hw/rtl/ffsc_back.sv
hw/rtl/fixed_frame_sync_checksum_unit.sv
bench/ffsc_checker.sv
bench/fixed_frame_sync_checksum_unit_tb.sv
